[hw/rtl/h2r_pkg.sv]
// shared constants and arithmetic helpers for the hsl to rgb converter
// no dependencies; used by the channel interfaces and the top level

package h2r_pkg;

  localparam int unsigned InW     = 16;
  localparam int unsigned OutW    = 8;
  localparam int unsigned NumChan = 3;

  // fraction scale: 65535 stands for one
  localparam int unsigned FullVal  = 65535;
  localparam int unsigned ThirdVal = 21845;
  // one, expressed over the common denominator 65535 * 65535
  localparam int unsigned LevelMax = 32'hFFFE0001;
  localparam int unsigned ByteMax  = 255;

  localparam logic [1:0] ChRed   = 2'd0;
  localparam logic [1:0] ChGreen = 2'd1;
  localparam logic [1:0] ChBlue  = 2'd2;

  // wrapped channel hue turned into the piecewise weight 0..65535
  function automatic logic [15:0] chan_weight(logic [15:0] hue, logic [1:0] ch);
    logic [16:0] x17;
    logic [15:0] x;
    logic [18:0] x6;
    logic [17:0] x3;
    logic [15:0] f;
    x17 = {1'b0, hue} + 17'(ThirdVal);
    unique case (ch)
      ChRed: begin
        x = (x17 > 17'(FullVal)) ? 16'(x17 - 17'(FullVal)) : x17[15:0];
      end
      ChBlue: begin
        x = (hue < 16'(ThirdVal)) ? 16'(hue + 16'(FullVal - ThirdVal)) :
                                    16'(hue - 16'(ThirdVal));
      end
      default: begin
        x = hue;
      end
    endcase
    x6 = {1'b0, x, 2'b00} + {2'b00, x, 1'b0};
    x3 = {2'b00, x} + {1'b0, x, 1'b0};
    priority if (x6 < 19'(FullVal)) begin
      f = x6[15:0];
    end else if ({1'b0, x, 1'b0} < 18'(FullVal)) begin
      f = 16'(FullVal);
    end else if (x3 < 18'(2 * FullVal)) begin
      f = 16'(19'(4 * FullVal) - x6);
    end else begin
      f = 16'd0;
    end
    return f;
  endfunction

  // first fold of a divide by 65535: n = (n >> 16) * 65535 + result
  function automatic logic [32:0] fold_lo(logic [47:0] n);
    return {1'b0, n[47:16]} + {17'd0, n[15:0]};
  endfunction

  // quotient of a first-fold remainder by 65535
  function automatic logic [17:0] fold_hi(logic [32:0] r1);
    logic [16:0] a2;
    logic [17:0] r2;
    logic [1:0]  corr;
    a2 = r1[32:16];
    r2 = {1'b0, a2} + {2'b00, r1[15:0]};
    priority if (r2 >= 18'(2 * FullVal)) begin
      corr = 2'd2;
    end else if (r2 >= 18'(FullVal)) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    return {1'b0, a2} + {16'd0, corr};
  endfunction

  // lightness / 257 for the gray case
  function automatic logic [7:0] gray_byte(logic [15:0] l);
    return (l[7:0] >= l[15:8]) ? l[15:8] : 8'(l[15:8] - 8'd1);
  endfunction

endpackage

[hw/rtl/h2r_hsl_if.sv]
// input channel: one hsl pixel per beat with valid/ready
// depends on h2r_pkg for field widths

interface h2r_hsl_if;
  logic                       valid;
  logic                       ready;
  logic [h2r_pkg::InW-1:0]    hue;
  logic [h2r_pkg::InW-1:0]    saturation;
  logic [h2r_pkg::InW-1:0]    lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

[hw/rtl/h2r_rgb_if.sv]
// output channel: one rgb pixel per beat with valid/ready
// depends on h2r_pkg for field widths

interface h2r_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [h2r_pkg::OutW-1:0]   red;
  logic [h2r_pkg::OutW-1:0]   green;
  logic [h2r_pkg::OutW-1:0]   blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

[hw/rtl/hsl_to_rgb_converter.sv]
// hsl to rgb converter, nine-stage pipeline
// depends on h2r_pkg, h2r_hsl_if and h2r_rgb_if
//
// usage:
// - hsl_i takes one pixel (hue, saturation, lightness, 16 bit fractions
//   where 65535 is one) per beat; rgb_o gives one 8 bit red, green, blue
//   pixel per beat, in the same order
// - structure: nine register stages, the last is the output register
// - throughput: one pixel per cycle while rgb_o is not stalled; stage
//   depth is set by the 32 bit fold adders of the divide-by-65535 steps
//   and by the 31x16 channel multipliers
// - stall: a full stage holds while the one after it holds, so hsl_i.ready
//   stays high as long as any stage holds a bubble and drops only when all
//   nine stages are occupied behind a stalled rgb_o
// - reset: rst_ni clears all stage valid bits; the pipeline is empty and
//   hsl_i.ready is high right after reset

module hsl_to_rgb_converter (
  input  logic      clk_i,
  input  logic      rst_ni,
  h2r_hsl_if.sink   hsl_i,
  h2r_rgb_if.source rgb_o
);
  import h2r_pkg::*;

  localparam int unsigned NumStages = 9;

  logic [NumStages-1:0] vld_q, vld_d, adv;

  logic        gf_d [NumStages-1];
  logic        gf_q [NumStages-1];
  logic [7:0]  gy_d [NumStages-1];
  logic [7:0]  gy_q [NumStages-1];

  logic [15:0] s0_sat_d, s0_sat_q, s0_l_d, s0_l_q;
  logic [14:0] s0_m_d, s0_m_q;
  logic [15:0] s0_f_d [NumChan];
  logic [15:0] s0_f_q [NumChan];

  logic [30:0] s1_sm_d, s1_sm_q;
  logic [15:0] s1_l_q;
  logic [15:0] s1_f_q [NumChan];

  logic [31:0] s2_v1_d, s2_v1_q;
  logic [46:0] s2_p_d [NumChan];
  logic [46:0] s2_p_q [NumChan];

  logic [31:0] s3_v1_q;
  logic [31:0] s3_a1_d [NumChan];
  logic [31:0] s3_a1_q [NumChan];
  logic [32:0] s3_r1_d [NumChan];
  logic [32:0] s3_r1_q [NumChan];

  logic [32:0] s4_sa_d [NumChan];
  logic [32:0] s4_sa_q [NumChan];
  logic [17:0] s4_q2_d [NumChan];
  logic [17:0] s4_q2_q [NumChan];

  logic [31:0] s5_lvl_d [NumChan];
  logic [31:0] s5_lvl_q [NumChan];

  logic [23:0] s6_a1_d [NumChan];
  logic [23:0] s6_a1_q [NumChan];
  logic [24:0] s6_r1_d [NumChan];
  logic [24:0] s6_r1_q [NumChan];

  logic [23:0] s7_q_d [NumChan];
  logic [23:0] s7_q_q [NumChan];

  logic [7:0]  s8_rgb_d [NumChan];
  logic [7:0]  s8_rgb_q [NumChan];

  // stage handshake
  assign adv[NumStages-1] = ~vld_q[NumStages-1] | rgb_o.ready;
  for (genvar g = 0; g < NumStages - 1; g++) begin : g_adv
    assign adv[g] = ~vld_q[g] | adv[g+1];
  end

  assign vld_d       = {vld_q[NumStages-2:0], hsl_i.valid};
  assign hsl_i.ready = adv[0];
  assign rgb_o.valid = vld_q[NumStages-1];
  assign rgb_o.red   = s8_rgb_q[ChRed];
  assign rgb_o.green = s8_rgb_q[ChGreen];
  assign rgb_o.blue  = s8_rgb_q[ChBlue];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  // gray side path
  always_comb begin
    gf_d[0] = (hsl_i.saturation == 16'd0);
    gy_d[0] = gray_byte(hsl_i.lightness);
    for (int k = 1; k < NumStages - 1; k++) begin
      gf_d[k] = gf_q[k-1];
      gy_d[k] = gy_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages - 1; k++) begin
      if (adv[k]) begin
        gf_q[k] <= gf_d[k];
        gy_q[k] <= gy_d[k];
      end
    end
  end

  // datapath next values
  always_comb begin
    logic [17:0] c_wide;
    logic [17:0] c_fold;
    logic [32:0] c_r;
    s0_sat_d = hsl_i.saturation;
    s0_l_d   = hsl_i.lightness;
    s0_m_d   = hsl_i.lightness[15] ? ~hsl_i.lightness[14:0] : hsl_i.lightness[14:0];
    s1_sm_d  = 31'(s0_sat_q) * 31'(s0_m_q);
    s2_v1_d  = {s1_l_q, 16'd0} - {16'd0, s1_l_q} - {1'b0, s1_sm_q};
    for (int c = 0; c < NumChan; c++) begin
      s0_f_d[c]   = chan_weight(hsl_i.hue, 2'(c));
      s2_p_d[c]   = 47'(s1_sm_q) * 47'(s1_f_q[c]);
      s3_a1_d[c]  = s2_p_q[c][46:15];
      s3_r1_d[c]  = fold_lo({s2_p_q[c], 1'b0});
      s4_sa_d[c]  = {1'b0, s3_v1_q} + {1'b0, s3_a1_q[c]};
      s4_q2_d[c]  = fold_hi(s3_r1_q[c]);
      s5_lvl_d[c] = 32'(s4_sa_q[c] + {15'd0, s4_q2_q[c]});
      s6_a1_d[c]  = s5_lvl_q[c][31:8];
      s6_r1_d[c]  = 25'(fold_lo({8'd0, s5_lvl_q[c], 8'd0}));
      s7_q_d[c]   = 24'({1'b0, s6_a1_q[c]} + {7'd0, fold_hi({8'd0, s6_r1_q[c]})});
      c_r         = fold_lo({24'd0, s7_q_q[c]});
      c_fold      = fold_hi(c_r);
      c_wide      = {10'd0, s7_q_q[c][23:16]} + c_fold;
      if (gf_q[NumStages-2]) begin
        s8_rgb_d[c] = gy_q[NumStages-2];
      end else if (c_wide > 18'(ByteMax)) begin
        s8_rgb_d[c] = 8'(ByteMax);
      end else begin
        s8_rgb_d[c] = c_wide[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_sat_q <= s0_sat_d;
      s0_l_q   <= s0_l_d;
      s0_m_q   <= s0_m_d;
      s0_f_q   <= s0_f_d;
    end
    if (adv[1]) begin
      s1_sm_q <= s1_sm_d;
      s1_l_q  <= s0_l_q;
      s1_f_q  <= s0_f_q;
    end
    if (adv[2]) begin
      s2_v1_q <= s2_v1_d;
      s2_p_q  <= s2_p_d;
    end
    if (adv[3]) begin
      s3_v1_q <= s2_v1_q;
      s3_a1_q <= s3_a1_d;
      s3_r1_q <= s3_r1_d;
    end
    if (adv[4]) begin
      s4_sa_q <= s4_sa_d;
      s4_q2_q <= s4_q2_d;
    end
    if (adv[5]) begin
      s5_lvl_q <= s5_lvl_d;
    end
    if (adv[6]) begin
      s6_a1_q <= s6_a1_d;
      s6_r1_q <= s6_r1_d;
    end
    if (adv[7]) begin
      s7_q_q <= s7_q_d;
    end
    if (adv[8]) begin
      s8_rgb_q <= s8_rgb_d;
    end
  end

  // input backpressure only when every stage is occupied
  a_full_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsl_i.ready |-> (&vld_q && !rgb_o.ready))
    else $error("input blocked with a bubble in the pipeline");

  // channel level never exceeds one
  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (s5_lvl_q[0] <= LevelMax) && (s5_lvl_q[1] <= LevelMax) &&
                 (s5_lvl_q[2] <= LevelMax))
    else $error("channel level above full scale");

  // scaled channel stays within 256 * 65535
  a_scaled_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] |-> (s7_q_q[0] <= 24'(256 * FullVal)) && (s7_q_q[1] <= 24'(256 * FullVal)) &&
                 (s7_q_q[2] <= 24'(256 * FullVal)))
    else $error("scaled channel out of range");

endmodule

[dv/testbench.sv]
// self-checking testbench for hsl_to_rgb_converter: directed and random pixels, random stalls
// depends on h2r_pkg, h2r_hsl_if, h2r_rgb_if and the converter rtl

module testbench;

  localparam bit [63:0] FracOne = 64'd65535;
  localparam bit [63:0] DenomD  = 64'd4294836225;
  localparam bit [63:0] ThirdD  = 64'd1431612075;
  localparam int        NumRandom = 1600;

  typedef struct packed {
    logic [h2r_pkg::OutW-1:0] red;
    logic [h2r_pkg::OutW-1:0] green;
    logic [h2r_pkg::OutW-1:0] blue;
  } rgb_pixel_t;

  logic clk_i;
  logic rst_ni;

  h2r_hsl_if hsl ();
  h2r_rgb_if rgb ();

  hsl_to_rgb_converter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsl_i  (hsl),
    .rgb_o  (rgb)
  );

  rgb_pixel_t expected_rgb_q [$];
  int         error_count = 0;
  bit         no_idle = 1'b0;
  string      chan_name [3] = '{"red", "green", "blue"};

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("hsl_to_rgb_converter regression: fail");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  // one channel: wrap the channel hue, evaluate the piecewise level, scale to a byte
  function automatic logic [7:0] channel_byte(bit [63:0] lo, bit [63:0] hi, longint hue_d);
    longint    xs;
    bit [63:0] x;
    bit [63:0] span;
    bit [63:0] level;
    bit [63:0] scaled;
    xs   = hue_d;
    span = hi - lo;
    if (xs < 0) xs += longint'(DenomD);
    if (xs > longint'(DenomD)) xs -= longint'(DenomD);
    x = 64'(xs);
    if (6 * x < DenomD) begin
      level = lo + (span * (6 * x)) / DenomD;
    end else if (2 * x < DenomD) begin
      level = hi;
    end else if (3 * x < 2 * DenomD) begin
      level = lo + (span * (4 * DenomD - 6 * x)) / DenomD;
    end else begin
      level = lo;
    end
    scaled = (level * 256) / DenomD;
    return (scaled > 255) ? 8'd255 : scaled[7:0];
  endfunction

  function automatic rgb_pixel_t predict_rgb(logic [15:0] hue, logic [15:0] sat,
                                             logic [15:0] light);
    bit [63:0]  h;
    bit [63:0]  s;
    bit [63:0]  l;
    bit [63:0]  hi;
    bit [63:0]  lo;
    longint     hd;
    rgb_pixel_t px;
    h = hue;
    s = sat;
    l = light;
    if (s == 0) begin
      px.red   = 8'(l / 257);
      px.green = px.red;
      px.blue  = px.red;
      return px;
    end
    if (2 * l < FracOne) begin
      hi = l * (FracOne + s);
    end else begin
      hi = (l + s) * FracOne - s * l;
    end
    lo = 2 * l * FracOne - hi;
    hd = longint'(h * FracOne);
    px.red   = channel_byte(lo, hi, hd + longint'(ThirdD));
    px.green = channel_byte(lo, hi, hd);
    px.blue  = channel_byte(lo, hi, hd - longint'(ThirdD));
    return px;
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 7))
      0: begin
        return 16'd0;
      end
      1: begin
        return 16'hFFFF;
      end
      2: begin
        // near multiples of one third
        return 16'(21845 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  task automatic send_pixel(input logic [15:0] hue, input logic [15:0] sat,
                            input logic [15:0] light);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      hsl.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    hsl.valid      <= 1'b1;
    hsl.hue        <= hue;
    hsl.saturation <= sat;
    hsl.lightness  <= light;
    do @(posedge clk_i); while (!hsl.ready);
    expected_rgb_q.push_back(predict_rgb(hue, sat, light));
  endtask

  task automatic test_gray_levels();
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'd12345, 16'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0, 16'd257);
    send_pixel(16'd0, 16'd0, 16'd256);
  endtask

  task automatic test_full_channel();
    send_pixel(16'd0, 16'hFFFF, 16'd32768);
    send_pixel(16'd21845, 16'hFFFF, 16'd32768);
    send_pixel(16'd43690, 16'hFFFF, 16'd32768);
    send_pixel(16'd100, 16'd1, 16'hFFFF);
    send_pixel(16'd0, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_hue_wrap();
    send_pixel(16'd0, 16'hFFFF, 16'd32767);
    send_pixel(16'hFFFF, 16'hFFFF, 16'd32767);
    send_pixel(16'd43690, 16'hFFFF, 16'd32767);
    send_pixel(16'd43691, 16'hFFFF, 16'd32767);
    send_pixel(16'd21845, 16'hFFFF, 16'd32767);
    send_pixel(16'd21844, 16'hFFFF, 16'd32767);
  endtask

  task automatic test_field_extremes();
    send_pixel(16'hFFFF, 16'hFFFF, 16'd0);
    send_pixel(16'd0, 16'd1, 16'd1);
    send_pixel(16'hFFFF, 16'd1, 16'd32767);
    send_pixel(16'd32767, 16'hFFFF, 16'd32767);
    send_pixel(16'd10922, 16'd40000, 16'd20000);
    send_pixel(16'd54613, 16'hFFFF, 16'd40000);
  endtask

  task automatic test_random_pixels();
    logic [15:0] h;
    logic [15:0] s;
    logic [15:0] l;
    for (int i = 0; i < NumRandom; i++) begin
      // every fourth stretch runs without idling on either side
      no_idle = ((i % 400) >= 300);
      h = rand_field();
      s = ($urandom_range(0, 9) == 0) ? 16'd0 : rand_field();
      l = rand_field();
      send_pixel(h, s, l);
    end
    no_idle = 1'b0;
  endtask

  initial begin : rgb_stall
    int gap;
    rgb.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        @(negedge clk_i);
        rgb.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      rgb.ready <= 1'b1;
      do @(posedge clk_i); while (!rgb.valid);
    end
  end

  always @(posedge clk_i) begin : rgb_check
    rgb_pixel_t want;
    rgb_pixel_t got;
    if (rst_ni && rgb.valid && rgb.ready) begin
      got = {rgb.red, rgb.green, rgb.blue};
      if (expected_rgb_q.size() == 0) begin
        $display("%0t: rgb beat with none expected, actual r=%0d g=%0d b=%0d",
                 $time, got.red, got.green, got.blue);
        error_count++;
      end else begin
        want = expected_rgb_q.pop_front();
        for (int ch = 0; ch < 3; ch++) begin
          if (want[(2 - ch) * 8 +: 8] !== got[(2 - ch) * 8 +: 8]) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, chan_name[ch],
                     want[(2 - ch) * 8 +: 8], got[(2 - ch) * 8 +: 8]);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    hsl.valid      <= 1'b0;
    hsl.hue        <= '0;
    hsl.saturation <= '0;
    hsl.lightness  <= '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_gray_levels();
    test_full_channel();
    test_hue_wrap();
    test_field_extremes();
    test_random_pixels();

    @(negedge clk_i);
    hsl.valid <= 1'b0;
    while (expected_rgb_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("hsl_to_rgb_converter regression: pass");
    end else begin
      $display("hsl_to_rgb_converter regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/h2r_pkg.sv
hw/rtl/h2r_hsl_if.sv
hw/rtl/h2r_rgb_if.sv
hw/rtl/hsl_to_rgb_converter.sv
dv/testbench.sv
